@@ hdl/etcb_pkg.sv @@
// shared types and constants for the event trace capture buffer
package etcb_pkg;

  // default number of trace entries
  localparam int CAPACITY_DEF = 1024;

  // byte accounting for the byte_total report, and the tick width
  localparam int HDR_BYTES   = 64;
  localparam int TICK_W      = 64;

  // operation codes
  localparam logic [2:0] OP_EVENT = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADOP  = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  // input word
  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  src_domain;
    logic [7:0]  dst_domain;
    logic [15:0] msg_label;
    logic [31:0] data_word_a;
    logic [31:0] data_word_b;
    logic [9:0]  read_index;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]        status;
    logic [10:0]       entry_count;
    logic [14:0]       byte_total;
    logic              is_recording;
    logic              has_overflowed;
    logic [TICK_W-1:0] entry_tick;
    logic [7:0]        entry_src;
    logic [7:0]        entry_dst;
    logic [15:0]       entry_label;
    logic [31:0]       entry_word_a;
    logic [31:0]       entry_word_b;
  } out_word_t;

  // one stored trace entry
  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [7:0]        src;
    logic [7:0]        dst;
    logic [15:0]       label;
    logic [31:0]       word_a;
    logic [31:0]       word_b;
  } entry_t;

endpackage

@@ hdl/etcb_store.sv @@
// trace entry memory: one write port, one registered read port
module etcb_store #(
  parameter int DEPTH = etcb_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  etcb_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output etcb_pkg::entry_t         rd_data
);

  etcb_pkg::entry_t mem [DEPTH];
  etcb_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/event_trace_capture_buffer.sv @@
// top level of the event trace capture buffer
// Takes one word per cycle on the input channel when the output side keeps up.
// Every operation is applied to the control state (count, tick, flags) and to
// the entry memory at the edge it is accepted; its result passes through one
// stage register, where the entry memory's registered read data arrives, and
// then an output register. Event words produce no result. The sustained rate
// is set by the output side; the entry memory, which has one write port and
// one read port, serves one word per cycle. Entries hold whatever was last
// written; only entries below the current count are ever returned.
module event_trace_capture_buffer #(
  parameter int CAPACITY = etcb_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  etcb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output etcb_pkg::out_word_t out_word
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 10) ? CNT_W : 10;
  localparam int OCW   = (CNT_W > 11) ? CNT_W : 11;
  localparam int BW    = (CNT_W + 6 > 15) ? CNT_W + 6 : 15;

  // control state
  logic                        rec_r, rec_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [etcb_pkg::TICK_W-1:0] tick_r, tick_nxt;

  // stage register
  logic             b_valid_r, b_valid_nxt;
  logic [1:0]       b_status_r, status_nxt;
  logic [CNT_W-1:0] b_count_r;
  logic             b_rec_r, b_ovf_r;
  logic             b_rd_ok_r, rd_ok;

  // output register
  logic                out_valid_r;
  etcb_pkg::out_word_t out_word_r;

  // memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  etcb_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  etcb_pkg::entry_t rd_data;

  logic             in_acc, b_move, full;
  logic [CMP_W-1:0] idx_ext;
  logic [BW-1:0]    cnt_bw, bytes_bw;
  logic [OCW-1:0]   cnt_out;

  // handshake
  assign b_move   = !out_valid_r || !out_stall;
  assign in_stall = b_valid_r && !b_move;
  assign in_acc   = in_valid && !in_stall;

  // read index check against the live count
  assign idx_ext = CMP_W'(in_word.read_index);
  assign rd_ok   = (in_word.operation == etcb_pkg::OP_READ)
                   && (idx_ext < CMP_W'(cnt_r));
  assign rd_addr = idx_ext[IDX_W-1:0];
  assign full    = (cnt_r == CNT_W'(CAPACITY));

  // entry written by an event
  assign wr_addr        = full ? '0 : cnt_r[IDX_W-1:0];
  assign wr_data.tick   = tick_r;
  assign wr_data.src    = in_word.src_domain;
  assign wr_data.dst    = in_word.dst_domain;
  assign wr_data.label  = in_word.msg_label;
  assign wr_data.word_a = in_word.data_word_a;
  assign wr_data.word_b = in_word.data_word_b;

  // operation decode and next control state
  always_comb begin
    rec_nxt     = rec_r;
    ovf_nxt     = ovf_r;
    cnt_nxt     = cnt_r;
    tick_nxt    = tick_r;
    wr_en       = 1'b0;
    status_nxt  = etcb_pkg::ST_OK;
    b_valid_nxt = 1'b1;
    unique case (in_word.operation)
      etcb_pkg::OP_EVENT: begin
        b_valid_nxt = 1'b0;
        if (rec_r) begin
          wr_en    = in_acc;
          tick_nxt = tick_r + 1'b1;
          if (full) begin
            ovf_nxt = 1'b1;
            cnt_nxt = CNT_W'(1);
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      etcb_pkg::OP_START: begin
        cnt_nxt  = '0;
        tick_nxt = '0;
        ovf_nxt  = 1'b0;
        rec_nxt  = 1'b1;
      end
      etcb_pkg::OP_STOP: begin
        rec_nxt = 1'b0;
      end
      etcb_pkg::OP_QUERY: begin
        status_nxt = etcb_pkg::ST_OK;
      end
      etcb_pkg::OP_READ: begin
        status_nxt = rd_ok ? etcb_pkg::ST_OK : etcb_pkg::ST_BADIDX;
      end
      default: begin
        status_nxt = etcb_pkg::ST_BADOP;
      end
    endcase
  end

  // control state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r       <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      tick_r      <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rec_r     <= rec_nxt;
        ovf_r     <= ovf_nxt;
        cnt_r     <= cnt_nxt;
        tick_r    <= tick_nxt;
        b_valid_r <= b_valid_nxt;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_status_r <= status_nxt;
      b_count_r  <= cnt_nxt;
      b_rec_r    <= rec_nxt;
      b_ovf_r    <= ovf_nxt;
      b_rd_ok_r  <= rd_ok;
    end
  end

  // bytes used: header plus twenty per entry
  assign cnt_bw   = BW'(b_count_r);
  assign bytes_bw = BW'(etcb_pkg::HDR_BYTES) + (cnt_bw << 4) + (cnt_bw << 2);
  assign cnt_out  = OCW'(b_count_r);

  // output payload
  always_ff @(posedge clk) begin
    if (b_move && b_valid_r) begin
      out_word_r.status         <= b_status_r;
      out_word_r.entry_count    <= cnt_out[10:0];
      out_word_r.byte_total     <= bytes_bw[14:0];
      out_word_r.is_recording   <= b_rec_r;
      out_word_r.has_overflowed <= b_ovf_r;
      out_word_r.entry_tick     <= b_rd_ok_r ? rd_data.tick   : '0;
      out_word_r.entry_src      <= b_rd_ok_r ? rd_data.src    : '0;
      out_word_r.entry_dst      <= b_rd_ok_r ? rd_data.dst    : '0;
      out_word_r.entry_label    <= b_rd_ok_r ? rd_data.label  : '0;
      out_word_r.entry_word_a   <= b_rd_ok_r ? rd_data.word_a : '0;
      out_word_r.entry_word_b   <= b_rd_ok_r ? rd_data.word_b : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // entry memory
  etcb_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
